@@ sv/rrc_pkg.sv @@
// Shared types, constants and register indexes of the rounded-rectangle coverage core.
package rrc_pkg;

    localparam int COORD_BITS_DEF     = 12;
    localparam int DIST_FRAC_BITS_DEF = 4;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_DATA_W = 40;

    localparam logic [CFG_ADDR_W-1:0] REG_RECT_X      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RECT_Y      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RECT_WIDTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RECT_HEIGHT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_FILL_MODE   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_THICKNESS   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_COLOR       = 3'd7;

    // Per-item classification that travels beside the distance pipeline.
    typedef struct packed {
        logic inbox;
        logic corner;
        logic edge_hit;
    } t_side;

    // One result item.
    typedef struct packed {
        logic       plot;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pix;

endpackage

@@ sv/rrc_front.sv @@
// Front pipeline: box and corner classification, squared offsets and the scaled sum.
module rrc_front #(
    parameter int COORD_BITS     = rrc_pkg::COORD_BITS_DEF,
    parameter int DIST_FRAC_BITS = rrc_pkg::DIST_FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [COORD_BITS-1:0]   i_pixel_x,
    input  logic [COORD_BITS-1:0]   i_pixel_y,
    input  logic [COORD_BITS-1:0]   i_rect_x,
    input  logic [COORD_BITS-1:0]   i_rect_y,
    input  logic [COORD_BITS-1:0]   i_rect_width,
    input  logic [COORD_BITS-1:0]   i_rect_height,
    input  logic [COORD_BITS-2:0]   i_corner_radius,
    input  logic [7:0]              i_border_thickness,
    output logic                    o_valid,
    output rrc_pkg::t_side          o_side,
    output logic [2*(COORD_BITS+DIST_FRAC_BITS+1)-1:0] o_n
);
    import rrc_pkg::*;

    localparam int SW = COORD_BITS + 2;
    localparam int MW = COORD_BITS + 1;
    localparam int QW = 2 * MW;
    localparam int NW = 2 * (COORD_BITS + DIST_FRAC_BITS + 1);

    logic signed [SW-1:0] s_u, s_v, s_w, s_h, s_r, s_t;
    logic signed [SW-1:0] s_wr, s_hr, s_wt, s_ht;
    logic signed [SW-1:0] s_cx, s_cy, s_ddx, s_ddy, s_dx2, s_dy2;
    logic                 w_inx, w_iny;
    logic [MW-1:0]        w_ax, w_ay;
    t_side                w_side;
    logic [QW:0]          w_sum;

    logic                 r_v1, r_v2, r_v3;
    t_side                r_side1, r_side2, r_side3;
    logic [MW-1:0]        r_ax, r_ay;
    logic [QW-1:0]        r_sqx, r_sqy;
    logic [NW-1:0]        r_n;

    assign s_u  = $signed({2'b00, i_pixel_x}) - $signed({2'b00, i_rect_x});
    assign s_v  = $signed({2'b00, i_pixel_y}) - $signed({2'b00, i_rect_y});
    assign s_w  = $signed({2'b00, i_rect_width});
    assign s_h  = $signed({2'b00, i_rect_height});
    assign s_r  = $signed({3'b000, i_corner_radius});
    assign s_t  = $signed({{(SW-8){1'b0}}, i_border_thickness});
    assign s_wr = s_w - s_r;
    assign s_hr = s_h - s_r;
    assign s_wt = s_w - s_t;
    assign s_ht = s_h - s_t;

    assign w_inx = (s_u >= s_r) && (s_u < s_wr);
    assign w_iny = (s_v >= s_r) && (s_v < s_hr);

    assign w_side.inbox    = (s_u >= 0) && (s_v >= 0) && (s_u < s_w) && (s_v < s_h);
    assign w_side.corner   = !w_inx && !w_iny;
    assign w_side.edge_hit = (w_inx && ((s_v < s_t) || (s_v >= s_ht))) ||
                             (w_iny && ((s_u < s_t) || (s_u >= s_wt)));

    // Oversized radius: a pixel left of r belongs to the left corner, else the right one.
    assign s_cx  = (s_u < s_r) ? s_r : s_wr;
    assign s_cy  = (s_v < s_r) ? s_r : s_hr;
    assign s_ddx = s_u - s_cx;
    assign s_ddy = s_v - s_cy;
    // Twice the offset plus one, i.e. the pixel centre in half-pixel units.
    assign s_dx2 = {s_ddx[SW-2:0], 1'b1};
    assign s_dy2 = {s_ddy[SW-2:0], 1'b1};
    assign w_ax  = s_dx2[SW-1] ? MW'(~s_dx2[MW-1:0] + 1'b1) : s_dx2[MW-1:0];
    assign w_ay  = s_dy2[SW-1] ? MW'(~s_dy2[MW-1:0] + 1'b1) : s_dy2[MW-1:0];

    assign w_sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1 <= w_side;
            r_ax    <= w_ax;
            r_ay    <= w_ay;
            r_side2 <= r_side1;
            r_sqx   <= r_ax * r_ax;
            r_sqy   <= r_ay * r_ay;
            r_side3 <= r_side2;
            r_n     <= NW'(w_sum) << (2 * DIST_FRAC_BITS - 2);
        end
    end

    assign o_valid = r_v3;
    assign o_side  = r_side3;
    assign o_n     = r_n;

endmodule

@@ sv/rrc_isqrt.sv @@
// Pipelined integer square root, one root bit per stage, with sideband carried along.
module rrc_isqrt #(
    parameter int ROOT_BITS = rrc_pkg::COORD_BITS_DEF + rrc_pkg::DIST_FRAC_BITS_DEF + 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  rrc_pkg::t_side           i_side,
    input  logic [2*ROOT_BITS-1:0]   i_n,
    output logic                     o_valid,
    output rrc_pkg::t_side           o_side,
    output logic [ROOT_BITS-1:0]     o_root
);
    import rrc_pkg::*;

    localparam int RW = ROOT_BITS + 2;
    localparam int NW = 2 * ROOT_BITS;

    logic                 r_vld  [0:ROOT_BITS-1];
    t_side                r_side [0:ROOT_BITS-1];
    logic [NW-1:0]        r_n    [0:ROOT_BITS-1];
    logic [RW-1:0]        r_rem  [0:ROOT_BITS-1];
    logic [ROOT_BITS-1:0] r_root [0:ROOT_BITS-1];

    genvar g;
    for (g = 0; g < ROOT_BITS; g++) begin : g_stage
        logic                 v_in;
        t_side                side_in;
        logic [NW-1:0]        n_in;
        logic [RW-1:0]        rem_in;
        logic [ROOT_BITS-1:0] root_in;
        logic [RW-1:0]        rem_sh;
        logic [RW-1:0]        trial;
        logic                 ge;

        if (g == 0) begin : g_first
            assign v_in    = i_valid;
            assign side_in = i_side;
            assign n_in    = i_n;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = r_vld[g-1];
            assign side_in = r_side[g-1];
            assign n_in    = r_n[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
        end

        // Bring down the next pair of radicand bits and try root*4+1.
        assign rem_sh = {rem_in[RW-3:0], n_in[2*(ROOT_BITS-1-g)+1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g] <= side_in;
                r_n[g]    <= n_in;
                r_rem[g]  <= ge ? (rem_sh - trial) : rem_sh;
                r_root[g] <= {root_in[ROOT_BITS-2:0], ge};
            end
        end
    end

    assign o_valid = r_vld[ROOT_BITS-1];
    assign o_side  = r_side[ROOT_BITS-1];
    assign o_root  = r_root[ROOT_BITS-1];

endmodule

@@ sv/rrc_shade.sv @@
// Coverage decision: plot flag and alpha from the corner distance and the classification.
module rrc_shade #(
    parameter int COORD_BITS     = rrc_pkg::COORD_BITS_DEF,
    parameter int DIST_FRAC_BITS = rrc_pkg::DIST_FRAC_BITS_DEF
) (
    input  logic [COORD_BITS+DIST_FRAC_BITS:0] i_dist,
    input  rrc_pkg::t_side                     i_side,
    input  logic [COORD_BITS-2:0]              i_corner_radius,
    input  logic [7:0]                         i_border_thickness,
    input  logic                               i_fill_mode,
    input  logic [31:0]                        i_color_rgba,
    output rrc_pkg::t_pix                      o_pix
);
    import rrc_pkg::*;

    localparam int DW = COORD_BITS + DIST_FRAC_BITS + 2;
    localparam int F  = DIST_FRAC_BITS;

    logic [DW-1:0]  w_d, w_rq, w_half, w_rq_hi, w_r, w_t, w_lo, w_diff;
    logic           w_opaque, w_ramp, w_t_gt, w_ring, w_plot;
    logic [F+7:0]   w_prod;
    logic [7:0]     w_alpha;

    assign w_d     = DW'(i_dist);
    assign w_rq    = DW'(i_corner_radius) << F;
    assign w_half  = DW'(1) << (F - 1);
    assign w_rq_hi = w_rq + w_half;
    assign w_r     = DW'(i_corner_radius);
    assign w_t     = DW'(i_border_thickness);

    assign w_opaque = (w_d + w_half) <= w_rq;
    assign w_ramp   = w_d < w_rq_hi;

    // Inside the ramp the distance is above r-0.5, so the difference stays below one pixel.
    assign w_diff  = w_rq_hi - w_d;
    assign w_prod  = i_color_rgba[7:0] * w_diff[F-1:0];

    // A thickness above the radius leaves no inner bound on the ring.
    assign w_t_gt = w_t > w_r;
    assign w_lo   = (w_r - w_t) << F;
    assign w_ring = i_side.corner && (w_t_gt || (w_d >= w_lo)) && (w_d <= w_rq_hi);

    always_comb begin
        w_plot  = 1'b0;
        w_alpha = i_color_rgba[7:0];
        if (i_side.inbox) begin
            if (i_fill_mode) begin
                if (!i_side.corner || w_opaque) begin
                    w_plot = 1'b1;
                end else if (w_ramp) begin
                    w_plot  = 1'b1;
                    w_alpha = w_prod[F+7:F];
                end
            end else begin
                w_plot = i_side.edge_hit || w_ring;
            end
        end
    end

    assign o_pix.plot  = w_plot;
    assign o_pix.red   = w_plot ? i_color_rgba[31:24] : 8'd0;
    assign o_pix.green = w_plot ? i_color_rgba[23:16] : 8'd0;
    assign o_pix.blue  = w_plot ? i_color_rgba[15:8]  : 8'd0;
    assign o_pix.alpha = w_plot ? w_alpha             : 8'd0;

endmodule

@@ sv/aa_rounded_rect_pixel_coverage_core.sv @@
// Top level of the antialiased rounded-rectangle pixel coverage core.
//
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_addr (rect_x, rect_y,
// rect_width, rect_height, corner_radius, fill_mode, border_thickness, color_rgba),
// taken at the clock edge with no wait. Write only while no item is in flight.
// Input stream: one pixel coordinate per item on the s_axis group.
// Output stream: one plot flag and RGBA value per item on the m_axis group, in order.
// Pipeline: the front stages, the square root stages and the output register lie between
// acceptance and o_m_axis_tvalid. The square root takes one root bit per pipeline stage
// and sets the depth.
// Throughput: one item per cycle while the receiver keeps taking results.
// Reset (synchronous, active low) empties the pipeline and the output stage and loads
// the register defaults: filled mode, thickness 2, white opaque color, all else zero.
// When the receiver stalls, the result holds on the output and one more item goes into
// a skid register; after that o_s_axis_tready drops and the whole pipeline holds until
// the output is taken. Nothing is lost or repeated.
module aa_rounded_rect_pixel_coverage_core #(
    parameter int COORD_BITS     = rrc_pkg::COORD_BITS_DEF,
    parameter int DIST_FRAC_BITS = rrc_pkg::DIST_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rrc_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [rrc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // Fields from bit 0 up: pixel_x, pixel_y, zero fill.
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]   i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // Fields from bit 0 up: plot, out_red, out_green, out_blue, out_alpha, zero fill.
    output logic [rrc_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata
);
    import rrc_pkg::*;

    localparam int RB = COORD_BITS + DIST_FRAC_BITS + 1;

    logic [COORD_BITS-1:0] r_rect_x, r_rect_y, r_rect_width, r_rect_height;
    logic [COORD_BITS-2:0] r_corner_radius;
    logic                  r_fill_mode;
    logic [7:0]            r_border_thickness;
    logic [31:0]           r_color_rgba;

    logic                  w_en;
    logic                  w_f_valid, w_q_valid;
    t_side                 w_f_side, w_q_side;
    logic [2*RB-1:0]       w_n;
    logic [RB-1:0]         w_root;
    t_pix                  w_pix;

    logic                  r_out_valid, r_sk_valid;
    t_pix                  r_out, r_sk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect_x           <= '0;
            r_rect_y           <= '0;
            r_rect_width       <= '0;
            r_rect_height      <= '0;
            r_corner_radius    <= '0;
            r_fill_mode        <= 1'b1;
            r_border_thickness <= 8'd2;
            r_color_rgba       <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_RECT_X:      r_rect_x           <= i_cfg_data[COORD_BITS-1:0];
                REG_RECT_Y:      r_rect_y           <= i_cfg_data[COORD_BITS-1:0];
                REG_RECT_WIDTH:  r_rect_width       <= i_cfg_data[COORD_BITS-1:0];
                REG_RECT_HEIGHT: r_rect_height      <= i_cfg_data[COORD_BITS-1:0];
                REG_RADIUS:      r_corner_radius    <= i_cfg_data[COORD_BITS-2:0];
                REG_FILL_MODE:   r_fill_mode        <= i_cfg_data[0];
                REG_THICKNESS:   r_border_thickness <= i_cfg_data[7:0];
                REG_COLOR:       r_color_rgba       <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // The pipeline moves whenever the skid register is free to catch its last item.
    assign w_en            = !r_sk_valid;
    assign o_s_axis_tready = w_en;

    rrc_front #(
        .COORD_BITS     (COORD_BITS),
        .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (w_en),
        .i_valid            (i_s_axis_tvalid),
        .i_pixel_x          (i_s_axis_tdata[COORD_BITS-1:0]),
        .i_pixel_y          (i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_rect_x           (r_rect_x),
        .i_rect_y           (r_rect_y),
        .i_rect_width       (r_rect_width),
        .i_rect_height      (r_rect_height),
        .i_corner_radius    (r_corner_radius),
        .i_border_thickness (r_border_thickness),
        .o_valid            (w_f_valid),
        .o_side             (w_f_side),
        .o_n                (w_n)
    );

    rrc_isqrt #(
        .ROOT_BITS (RB)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_side  (w_f_side),
        .i_n     (w_n),
        .o_valid (w_q_valid),
        .o_side  (w_q_side),
        .o_root  (w_root)
    );

    rrc_shade #(
        .COORD_BITS     (COORD_BITS),
        .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) u_shade (
        .i_dist             (w_root),
        .i_side             (w_q_side),
        .i_corner_radius    (r_corner_radius),
        .i_border_thickness (r_border_thickness),
        .i_fill_mode        (r_fill_mode),
        .i_color_rgba       (r_color_rgba),
        .o_pix              (w_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            if (r_sk_valid) begin
                r_out_valid <= 1'b1;
                r_out       <= r_sk;
                r_sk_valid  <= 1'b0;
            end else begin
                r_out_valid <= w_q_valid;
                r_out       <= w_pix;
            end
        end else if (w_q_valid && w_en) begin
            r_sk_valid <= 1'b1;
            r_sk       <= w_pix;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out.alpha, r_out.blue, r_out.green, r_out.red,
                              r_out.plot};

endmodule

@@ sv/rrc_checker.sv @@
// Port-level checker for the coverage core, with its bind to the top level.
module rrc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [rrc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import rrc_pkg::*;

    // Reset empties the output stage and the skid register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("output or skid not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output item changed");

    // An uncovered pixel carries no color.
    a_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[0] |-> o_m_axis_tdata[32:1] == 32'd0)
        else $error("uncovered pixel with nonzero color");

    // Input is refused only after the output was stalled.
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_axis_tready) |-> $past(o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input ready dropped without an output stall");

endmodule

bind aa_rounded_rect_pixel_coverage_core rrc_checker u_rrc_checker (.*);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the antialiased rounded-rectangle pixel coverage core.
module tb_top;
    import rrc_pkg::*;

    localparam int     CW           = COORD_BITS_DEF;
    localparam int     DIST_FRAC    = DIST_FRAC_BITS_DEF;
    localparam int     SQ_SHIFT     = 2 * DIST_FRAC - 2;
    localparam longint ONE_Q        = longint'(1) << DIST_FRAC;
    localparam longint HALF_Q       = longint'(1) << (DIST_FRAC - 1);
    localparam int     IN_W         = ((2 * CW + 7) / 8) * 8;
    localparam int     RANDOM_ITEMS = 1050;
    localparam int     MAX_COORD    = (1 << CW) - 1;
    localparam int     MAX_RADIUS   = (1 << (CW - 1)) - 1;

    // Shadow registers, coverage predictor and the queue of expected pixels.
    class coverage_board;
        logic [CW-1:0] left;
        logic [CW-1:0] top;
        logic [CW-1:0] width;
        logic [CW-1:0] height;
        logic [CW-2:0] radius;
        logic          filled;
        logic [7:0]    thickness;
        logic [31:0]   color;
        t_pix          expected_pixels[$];
        int            mismatches;
        int            results_seen;
        int            plotted_seen;

        function new();
            left         = '0;
            top          = '0;
            width        = '0;
            height       = '0;
            radius       = '0;
            filled       = 1'b1;
            thickness    = 8'd2;
            color        = '1;
            mismatches   = 0;
            results_seen = 0;
            plotted_seen = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_RECT_X:      left      = data[CW-1:0];
                REG_RECT_Y:      top       = data[CW-1:0];
                REG_RECT_WIDTH:  width     = data[CW-1:0];
                REG_RECT_HEIGHT: height    = data[CW-1:0];
                REG_RADIUS:      radius    = data[CW-2:0];
                REG_FILL_MODE:   filled    = data[0];
                REG_THICKNESS:   thickness = data[7:0];
                REG_COLOR:       color     = data;
                default: ;
            endcase
        endfunction

        function longint unsigned floor_sqrt(longint unsigned n);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = 24; b >= 0; b--) begin
                trial = root | (longint'(1) << b);
                if (trial * trial <= n) root = trial;
            end
            return root;
        endfunction

        function t_pix coverage_of(logic [CW-1:0] px, logic [CW-1:0] py);
            longint          u, v, w, h, r, t;
            longint          cx, cy, dx2, dy2, d, rq, ramp;
            longint unsigned sq;
            logic            inx, iny, corner, edge_hit, ring;
            t_pix            res;
            res = '0;
            u   = longint'(px) - longint'(left);
            v   = longint'(py) - longint'(top);
            w   = longint'(width);
            h   = longint'(height);
            r   = longint'(radius);
            t   = longint'(thickness);
            if (u >= 0 && v >= 0 && u < w && v < h) begin
                inx    = (u >= r) && (u < w - r);
                iny    = (v >= r) && (v < h - r);
                corner = !inx && !iny;
                cx     = (u < r) ? r : w - r;
                cy     = (v < r) ? r : h - r;
                dx2    = 2 * (u - cx) + 1;
                dy2    = 2 * (v - cy) + 1;
                sq     = dx2 * dx2 + dy2 * dy2;
                // Distance from the corner centre in Q.4, floor of the exact root.
                d      = longint'(floor_sqrt(sq << SQ_SHIFT));
                rq     = r * ONE_Q;
                if (filled) begin
                    if (!corner || d <= rq - HALF_Q) begin
                        res.plot  = 1'b1;
                        res.alpha = color[7:0];
                    end else if (d < rq + HALF_Q) begin
                        ramp      = longint'(color[7:0]) * (rq + HALF_Q - d);
                        res.plot  = 1'b1;
                        res.alpha = 8'(ramp >>> DIST_FRAC);
                    end
                end else begin
                    edge_hit = (inx && (v < t || v >= h - t)) || (iny && (u < t || u >= w - t));
                    ring     = corner && d >= (r - t) * ONE_Q && d <= rq + HALF_Q;
                    if (edge_hit || ring) begin
                        res.plot  = 1'b1;
                        res.alpha = color[7:0];
                    end
                end
            end
            if (res.plot) begin
                res.red   = color[31:24];
                res.green = color[23:16];
                res.blue  = color[15:8];
            end
            return res;
        endfunction

        function void note_pixel(logic [CW-1:0] px, logic [CW-1:0] py);
            t_pix want;
            want = coverage_of(px, py);
            if (want.plot) plotted_seen++;
            expected_pixels.push_back(want);
        endfunction

        function void check_pixel(logic [OUT_DATA_W-1:0] data);
            t_pix got;
            t_pix want;
            got.plot  = data[0];
            got.red   = data[8:1];
            got.green = data[16:9];
            got.blue  = data[24:17];
            got.alpha = data[32:25];
            results_seen++;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d arrived with nothing expected: plot=%0b rgba=%02h%02h%02h%02h",
                             results_seen, got.plot, got.red, got.green, got.blue, got.alpha);
                return;
            end
            want = expected_pixels.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d expected plot=%0b rgba=%02h%02h%02h%02h, got plot=%0b rgba=%02h%02h%02h%02h",
                             results_seen, want.plot, want.red, want.green, want.blue, want.alpha,
                             got.plot, got.red, got.green, got.blue, got.alpha);
            end
        endfunction
    endclass

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_W-1:0]       i_s_axis_tdata  = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    coverage_board board = new();
    bit            calm           = 1'b0;
    int            items_sent     = 0;
    int            settings_count = 0;

    aa_rounded_rect_pixel_coverage_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // The receiver stalls now and then, except during the calm stretch.
    always @(posedge i_clk) begin
        i_m_axis_tready <= calm || ($urandom_range(99) >= 11);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) board.check_pixel(o_m_axis_tdata);
    end

    initial begin
        #2000000;
        $display("aa_rounded_rect_pixel_coverage_core test failed");
        $finish;
    end

    // Fills the bits above a register's width with random junk one time in four.
    function automatic logic [CFG_DATA_W-1:0] junk_above(logic [CFG_DATA_W-1:0] value, int wid);
        logic [CFG_DATA_W-1:0] keep;
        keep = (wid >= CFG_DATA_W) ? '1 : ((CFG_DATA_W'(1) << wid) - 1);
        if ($urandom_range(3) == 0) return (value & keep) | ($urandom & ~keep);
        return value & keep;
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        board.write_reg(idx, value);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic setup(input int x, input int y, input int w, input int h, input int r,
                         input int fill, input int t, input logic [31:0] rgba);
        write_reg(REG_RECT_X,      junk_above(x, CW));
        write_reg(REG_RECT_Y,      junk_above(y, CW));
        write_reg(REG_RECT_WIDTH,  junk_above(w, CW));
        write_reg(REG_RECT_HEIGHT, junk_above(h, CW));
        write_reg(REG_RADIUS,      junk_above(r, CW - 1));
        write_reg(REG_FILL_MODE,   junk_above(fill, 1));
        write_reg(REG_THICKNESS,   junk_above(t, 8));
        write_reg(REG_COLOR,       rgba);
        settings_count++;
    endtask

    // Holds the input side low until every expected pixel has come back.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (board.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // tvalid is left high after an item so that back-to-back items need no toggle.
    task automatic send_pixel(input int px, input int py);
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        x = px[CW-1:0];
        y = py[CW-1:0];
        if (!calm && $urandom_range(99) < 11) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 11);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {y, x};
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_pixel(x, y);
        items_sent++;
    endtask

    task automatic directed_items();
        // Reset values give an empty rectangle, so nothing is covered.
        send_pixel(0, 0);
        send_pixel(MAX_COORD, MAX_COORD);
        wait_idle();

        setup(100, 50, 40, 30, 10, 1, 2, 32'h12345678);
        send_pixel(120, 65);
        send_pixel(103, 53);
        send_pixel(102, 53);
        send_pixel(100, 50);
        send_pixel(99, 60);
        send_pixel(140, 60);
        send_pixel(139, 79);
        wait_idle();

        // A tiny base alpha makes the ramp truncate to zero while still plotting.
        write_reg(REG_COLOR, 32'hA0B0C001);
        send_pixel(102, 53);
        wait_idle();

        setup(100, 50, 40, 30, 10, 0, 2, 32'hFF00FF80);
        send_pixel(120, 50);
        send_pixel(120, 52);
        send_pixel(102, 53);
        send_pixel(105, 55);
        send_pixel(100, 65);
        wait_idle();

        // Outline thicker than the radius.
        setup(0, 0, 20, 20, 4, 0, 255, 32'hFFFFFFFF);
        send_pixel(1, 1);
        send_pixel(10, 10);
        wait_idle();

        // Radius too large for the box: the cross is empty in both directions.
        setup(4090, 4090, 6, 5, 3, 1, 2, 32'h0055AAFF);
        send_pixel(4092, 4092);
        send_pixel(4094, 4094);
        wait_idle();

        setup(0, 0, MAX_COORD, MAX_COORD, MAX_RADIUS, 1, 0, 32'h00000000);
        write_reg(REG_COLOR, 32'h89ABCDEF);
        send_pixel(0, 2047);
        send_pixel(600, 600);
        send_pixel(MAX_COORD, MAX_COORD);
        wait_idle();
    endtask

    task automatic random_setting(output int x, output int y, output int w, output int h,
                                  output int r);
        int          lim;
        int          fill;
        int          t;
        logic [31:0] rgba;
        case ($urandom_range(9))
            0: begin
                w = $urandom_range(0, MAX_COORD);
                h = $urandom_range(0, MAX_COORD);
            end
            1: begin
                w = MAX_COORD;
                h = MAX_COORD;
            end
            default: begin
                w = $urandom_range(0, 48);
                h = $urandom_range(0, 48);
            end
        endcase
        lim = ((w < h) ? w : h) / 2;
        case ($urandom_range(7))
            0:       r = $urandom_range(0, MAX_RADIUS);
            1:       r = lim;
            2:       r = 0;
            3:       r = lim + $urandom_range(1, 3);
            default: r = $urandom_range(0, lim);
        endcase
        if (r > MAX_RADIUS) r = MAX_RADIUS;
        case ($urandom_range(5))
            0:       x = 0;
            1:       x = MAX_COORD - $urandom_range(0, 20);
            default: x = $urandom_range(0, MAX_COORD);
        endcase
        case ($urandom_range(5))
            0:       y = 0;
            1:       y = MAX_COORD - $urandom_range(0, 20);
            default: y = $urandom_range(0, MAX_COORD);
        endcase
        fill = $urandom_range(1);
        case ($urandom_range(5))
            0:       t = 0;
            1:       t = 255;
            default: t = $urandom_range(0, 12);
        endcase
        case ($urandom_range(7))
            0:       rgba = 32'h00000000;
            1:       rgba = 32'hFFFFFFFF;
            default: rgba = $urandom;
        endcase
        setup(x, y, w, h, r, fill, t, rgba);
    endtask

    // Most pixels land near a corner or inside the box, where the work is.
    task automatic random_pixel(input int x, input int y, input int w, input int h,
                                input int r);
        int ox;
        int oy;
        case ($urandom_range(9))
            0: send_pixel($urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD));
            1, 2: send_pixel(x + $urandom_range(0, w + 3) - 2, y + $urandom_range(0, h + 3) - 2);
            default: begin
                ox = $urandom_range(0, r + 2);
                oy = $urandom_range(0, r + 2);
                send_pixel($urandom_range(1) ? x + ox - 1 : x + w - ox,
                           $urandom_range(1) ? y + oy - 1 : y + h - oy);
            end
        endcase
    endtask

    initial begin
        int x, y, w, h, r;
        int phase;
        int phase_items;
        int goal;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_items();

        goal  = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < goal) begin
            calm = (phase >= 8 && phase <= 11);
            random_setting(x, y, w, h, r);
            phase_items = $urandom_range(20, 45);
            for (int i = 0; i < phase_items; i++) begin
                if (phase == 3 && i == phase_items / 2) wait_idle();
                random_pixel(x, y, w, h, r);
            end
            wait_idle();
            phase++;
        end
        calm = 1'b0;

        wait_idle();
        repeat (30) @(posedge i_clk);
        $display("Classified %0d pixels under %0d register settings, filled and outline, %0d plotted.",
                 items_sent, settings_count, board.plotted_seen);
        $display("Results checked: %0d, mismatches: %0d.", board.results_seen, board.mismatches);
        if (board.mismatches == 0 && board.expected_pixels.size() == 0) begin
            $display("aa_rounded_rect_pixel_coverage_core test passed");
        end else begin
            $display("aa_rounded_rect_pixel_coverage_core test failed");
        end
        $finish;
    end

endmodule
